FILE: rtl/plcm_pkg.sv
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared types and constants of the piecewise linear color map.
// ----------------------------------------------------------------------------
package plcm_pkg;

	localparam int POS_BITS = 16;
	localparam int OUT_BITS = 8;
	localparam int NUM_CH   = 3;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic [1:0] CH_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_SHIFT,
		ST_SH_WR,
		ST_LO_RD,
		ST_LO_CAP,
		ST_SPAN,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} plcm_state_t;

	typedef struct packed {
		logic load;
		logic rd_search;
		logic idx_inc;
		logic set_miss;
		logic set_full;
		logic jset;
		logic sh_rd;
		logic sh_wr;
		logic wr_new;
		logic hit_cap;
		logic lo_rd;
		logic lo_cap;
		logic span_cap;
		logic zero_span;
		logic ch_clr;
		logic mul;
		logic div_step;
		logic acc;
		logic out_load;
	} plcm_cmd_t;

	typedef struct packed {
		logic is_ins;
		logic full;
		logic at_end;
		logic ge;
		logic sh_more;
		logic idx_zero;
		logic span_zero;
		logic div_done;
		logic ch_last;
		logic out_free;
	} plcm_sts_t;

endpackage

FILE: rtl/plcm_ctrl.sv
// ----------------------------------------------------------------------------
// plcm_ctrl
// Sequencer for search, insert shifting and per-channel interpolation.
// ----------------------------------------------------------------------------
module plcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  plcm_pkg::plcm_sts_t sts,
	output plcm_pkg::plcm_cmd_t cmd
);
	import plcm_pkg::*;

	plcm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				if (sts.is_ins && sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = ST_DONE;
				end else if (sts.at_end) begin
					if (sts.is_ins) begin
						cmd.jset = 1'b1;
						state_d  = ST_SHIFT;
					end else begin
						cmd.set_miss = 1'b1;
						state_d      = ST_DONE;
					end
				end else begin
					cmd.rd_search = 1'b1;
					state_d       = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.ge) begin
					if (sts.is_ins) begin
						cmd.jset = 1'b1;
						state_d  = ST_SHIFT;
					end else begin
						cmd.hit_cap = 1'b1;
						state_d     = ST_LO_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_RD;
				end
			end
			ST_SHIFT: begin
				if (sts.sh_more) begin
					cmd.sh_rd = 1'b1;
					state_d   = ST_SH_WR;
				end else begin
					cmd.wr_new = 1'b1;
					state_d    = ST_DONE;
				end
			end
			ST_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = ST_SHIFT;
			end
			ST_LO_RD: begin
				// The first point interpolates from black at position zero.
				if (sts.idx_zero) begin
					state_d = ST_SPAN;
				end else begin
					cmd.lo_rd = 1'b1;
					state_d   = ST_LO_CAP;
				end
			end
			ST_LO_CAP: begin
				cmd.lo_cap = 1'b1;
				state_d    = ST_SPAN;
			end
			ST_SPAN: begin
				cmd.span_cap = 1'b1;
				if (sts.span_zero) begin
					cmd.zero_span = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.ch_clr = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.acc = 1'b1;
					state_d = sts.ch_last ? ST_DONE : ST_MUL;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/plcm_dp.sv
// ----------------------------------------------------------------------------
// plcm_dp
// Point table memory, search registers, multiplier, divider and output register.
// ----------------------------------------------------------------------------
module plcm_dp #(
	parameter int MAX_POINTS   = 16,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plcm_pkg::plcm_cmd_t           cmd,
	output plcm_pkg::plcm_sts_t           sts,
	input  logic                          action,
	input  logic [plcm_pkg::POS_BITS-1:0] position,
	input  logic [CHANNEL_BITS-1:0]       red_in,
	input  logic [CHANNEL_BITS-1:0]       green_in,
	input  logic [CHANNEL_BITS-1:0]       blue_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [plcm_pkg::OUT_BITS-1:0] red_out,
	output logic [plcm_pkg::OUT_BITS-1:0] green_out,
	output logic [plcm_pkg::OUT_BITS-1:0] blue_out,
	output logic [1:0]                    status
);
	import plcm_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CB = CHANNEL_BITS;
	localparam int NW = CB + POS_BITS;
	localparam int KW = $clog2(CB + 1);
	localparam int COLW = NUM_CH * CB;

	logic [POS_BITS-1:0] pos_mem [MAX_POINTS];
	logic [COLW-1:0]     col_mem [MAX_POINTS];

	logic [CW-1:0]       count_q, idx_q, j_q;
	logic                act_q;
	logic [POS_BITS-1:0] pos_q, rpos_q, p0_q, p1_q, span_q, num_q;
	logic [COLW-1:0]     col_q, rcol_q;
	logic [CB-1:0]       c0_q [NUM_CH];
	logic [CB-1:0]       c1_q [NUM_CH];
	logic [CB-1:0]       res_q [NUM_CH];
	logic [1:0]          stat_q, ch_q;
	logic [POS_BITS-1:0] rem_q;
	logic [CB-1:0]       qs_q;
	logic [KW-1:0]       cnt_q;
	logic                dec_q;
	logic                out_valid_q;

	logic [CW-1:0]       idx_m1, j_m1;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic                rd_en, wr_en;
	logic [POS_BITS-1:0] wr_pos;
	logic [COLW-1:0]     wr_col;
	logic [CB-1:0]       ca, cb_v, diff;
	logic                dec;
	logic [NW-1:0]       n_full;
	logic [POS_BITS:0]   trial;
	logic                qbit;

	assign idx_m1 = idx_q - CW'(1);
	assign j_m1   = j_q - CW'(1);

	always_comb begin
		rd_en = cmd.rd_search | cmd.sh_rd | cmd.lo_rd;
		if (cmd.sh_rd) begin
			rd_addr = j_m1[AW-1:0];
		end else if (cmd.lo_rd) begin
			rd_addr = idx_m1[AW-1:0];
		end else begin
			rd_addr = idx_q[AW-1:0];
		end
		wr_en = cmd.sh_wr | cmd.wr_new;
		if (cmd.sh_wr) begin
			wr_addr = j_q[AW-1:0];
			wr_pos  = rpos_q;
			wr_col  = rcol_q;
		end else begin
			wr_addr = idx_q[AW-1:0];
			wr_pos  = pos_q;
			wr_col  = col_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_addr] <= wr_pos;
			col_mem[wr_addr] <= wr_col;
		end
		if (rd_en) begin
			rpos_q <= pos_mem[rd_addr];
			rcol_q <= col_mem[rd_addr];
		end
	end

	// Magnitude of the channel step; a falling channel rounds its drop up.
	always_comb begin
		ca     = c0_q[ch_q];
		cb_v   = c1_q[ch_q];
		dec    = cb_v < ca;
		diff   = dec ? (ca - cb_v) : (cb_v - ca);
		n_full = NW'(diff) * NW'(num_q)
		       + (dec ? NW'(span_q - POS_BITS'(1)) : NW'(0));
		trial  = {rem_q, qs_q[CB-1]};
		qbit   = trial >= {1'b0, span_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_new) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			pos_q  <= position;
			col_q  <= {red_in, green_in, blue_in};
			idx_q  <= '0;
			stat_q <= STAT_OK;
			for (int k = 0; k < NUM_CH; k++) begin
				res_q[k] <= '0;
			end
		end
		if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.set_miss) begin
			stat_q <= STAT_MISS;
		end
		if (cmd.set_full) begin
			stat_q <= STAT_FULL;
		end
		if (cmd.jset) begin
			j_q <= count_q;
		end
		if (cmd.sh_wr) begin
			j_q <= j_m1;
		end
		if (cmd.hit_cap) begin
			p1_q <= rpos_q;
			p0_q <= '0;
			for (int k = 0; k < NUM_CH; k++) begin
				c1_q[k] <= rcol_q[(NUM_CH - 1 - k) * CB +: CB];
				c0_q[k] <= '0;
			end
		end
		if (cmd.lo_cap) begin
			p0_q <= rpos_q;
			for (int k = 0; k < NUM_CH; k++) begin
				c0_q[k] <= rcol_q[(NUM_CH - 1 - k) * CB +: CB];
			end
		end
		if (cmd.span_cap) begin
			span_q <= p1_q - p0_q;
			num_q  <= pos_q - p0_q;
		end
		if (cmd.zero_span) begin
			for (int k = 0; k < NUM_CH; k++) begin
				res_q[k] <= c1_q[k];
			end
		end
		if (cmd.ch_clr) begin
			ch_q <= '0;
		end
		// The quotient never exceeds the channel step, so CB steps suffice.
		if (cmd.mul) begin
			rem_q <= n_full[NW-1:CB];
			qs_q  <= n_full[CB-1:0];
			cnt_q <= '0;
			dec_q <= dec;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? POS_BITS'(trial - {1'b0, span_q}) : trial[POS_BITS-1:0];
			qs_q  <= {qs_q[CB-2:0], qbit};
			cnt_q <= cnt_q + KW'(1);
		end
		if (cmd.acc) begin
			res_q[ch_q] <= dec_q ? (c0_q[ch_q] - qs_q) : (c0_q[ch_q] + qs_q);
			ch_q        <= ch_q + 2'd1;
		end
		if (cmd.out_load) begin
			red_out   <= OUT_BITS'(res_q[0]);
			green_out <= OUT_BITS'(res_q[1]);
			blue_out  <= OUT_BITS'(res_q[2]);
			status    <= stat_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.is_ins    = act_q == ACT_INSERT;
		sts.full      = count_q == CW'(MAX_POINTS);
		sts.at_end    = idx_q == count_q;
		sts.ge        = rpos_q >= pos_q;
		sts.sh_more   = j_q > idx_q;
		sts.idx_zero  = idx_q == '0;
		sts.span_zero = p1_q == p0_q;
		sts.div_done  = cnt_q == KW'(CB);
		sts.ch_last   = ch_q == CH_LAST;
		sts.out_free  = !out_valid_q || !out_stall;
	end

endmodule

FILE: rtl/piecewise_linear_color_map.sv
// A search reads and compares each stored point in turn. An insert then moves
// up each later point, one memory port shifting one entry at a time. A lookup
// uses one shared multiplier, per channel in turn, and a radix-2 divider
// producing one quotient bit per cycle. One item is in work at a time; the
// output register lets the next item enter while a result waits. Reset empties
// the table; stored points are not cleared.
// ----------------------------------------------------------------------------
// piecewise_linear_color_map
// Sorted table of color control points with linear interpolation lookups.
// ----------------------------------------------------------------------------
module piecewise_linear_color_map #(
	parameter int MAX_POINTS   = 16,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [plcm_pkg::POS_BITS-1:0] position,
	input  logic [CHANNEL_BITS-1:0]       red_in,
	input  logic [CHANNEL_BITS-1:0]       green_in,
	input  logic [CHANNEL_BITS-1:0]       blue_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [plcm_pkg::OUT_BITS-1:0] red_out,
	output logic [plcm_pkg::OUT_BITS-1:0] green_out,
	output logic [plcm_pkg::OUT_BITS-1:0] blue_out,
	output logic [1:0]                    status
);
	import plcm_pkg::*;

	plcm_cmd_t cmd;
	plcm_sts_t sts;

	plcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	plcm_dp #(
		.MAX_POINTS   (MAX_POINTS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.position  (position),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.status    (status)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block took a second item while one was in work");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_new && sts.full))
		else $error("insert written into a full table");

	a_error_colors_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_OK) |->
		(red_out == '0 && green_out == '0 && blue_out == '0))
		else $error("error result carries a color");

endmodule
